// File: hdl/kcal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_pkg
// Shared types and codes for the keyed calibration averager.
// ----------------------------------------------------------------------------
package kcal_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;
  localparam logic [2:0] OP_FINISH = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ADDR_ZERO  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_CALIBRATED = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  localparam logic [7:0] MAX_SAMPLES_RESET = 8'd10;

  typedef struct packed {
    logic [15:0] key;
    logic [39:0] rsum;
    logic [23:0] psum;
    logic [7:0]  cnt;
    logic        cal;
  } entry_t;

  typedef struct packed {
    logic       load_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_en;
    logic       rd_sel_next;
    logic       ent_load;
    logic       wr_add;
    logic       wr_upd;
    logic       wr_shift;
    logic       occ_clr;
    logic       occ_dec;
    logic       fin_set;
    logic       fin_and;
    logic       st_load;
    logic [2:0] st_val;
    logic       rep_set;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       addr_zero;
    logic       full;
    logic       idx_lt_occ;
    logic       nxt_lt_occ;
    logic       key_match;
    logic       rd_cal;
    logic       div_busy;
    logic       out_free;
  } sts_t;

endpackage

// File: hdl/kcal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/kcal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_div
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module kcal_div #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [7:0]   divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    q;
  logic [7:0]      rem;
  logic [7:0]      dv;
  logic            neg;
  logic [CNTW-1:0] cnt;
  logic [8:0]      trial;
  logic            fits;

  assign trial = {rem, q[W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[W-1];
      q   <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      // shift in the next dividend bit and subtract where it fits
      q   <= {q[W-2:0], fits};
      rem <= fits ? 8'(trial - {1'b0, dv}) : trial[7:0];
    end
  end

  assign quotient = neg ? (~q + 1'b1) : q;

endmodule

// File: hdl/kcal_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_datapath
// Entry table, scan index, sample accumulation, dividers and result register.
// ----------------------------------------------------------------------------
module kcal_datapath import kcal_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         op,
  input  logic [15:0]        anchor_address,
  input  logic signed [31:0] range_sample,
  input  logic signed [15:0] dbm_sample,
  input  logic [15:0]        expected_anchors,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] average_range,
  output logic signed [15:0] average_dbm,
  output logic [7:0]         sample_count,
  output logic               calibrated,
  output logic               finished,
  output logic [4:0]         entry_count
);

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int EW = $bits(entry_t);

  logic [2:0]    op_q;
  logic [15:0]   addr_q;
  logic [31:0]   rs_q;
  logic [15:0]   ds_q;
  logic [15:0]   exp_q;
  logic [7:0]    max_samples;
  logic [CW-1:0] occ;
  logic [CW-1:0] idx;
  logic [CW:0]   idx_nxt;
  entry_t        ent;
  entry_t        rd_ent;
  entry_t        upd;
  entry_t        wr_ent;
  logic [EW-1:0] rd_word;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          we;
  logic [2:0]    st_q;
  logic          rep;
  logic          fin;
  logic          busy_r;
  logic          busy_p;
  logic [39:0]   q_r;
  logic [23:0]   q_p;
  logic [CW+15:0] occ_w16;
  logic [CW+4:0]  occ_w5;
  logic           exp_ok;

  assign idx_nxt = {1'b0, idx} + 1'b1;
  assign rd_ent  = entry_t'(rd_word);

  always_comb begin
    upd.key  = rd_ent.key;
    upd.rsum = rd_ent.rsum + {{8{rs_q[31]}}, rs_q};
    upd.psum = rd_ent.psum + {{8{ds_q[15]}}, ds_q};
    upd.cnt  = rd_ent.cnt + 8'd1;
    upd.cal  = (rd_ent.cnt + 8'd1) >= max_samples;
  end

  always_comb begin
    wr_ent = rd_ent;
    if (cmd.wr_add) begin
      wr_ent     = '0;
      wr_ent.key = addr_q;
    end else if (cmd.wr_upd) begin
      wr_ent = upd;
    end
  end

  assign we      = cmd.wr_add | cmd.wr_upd | cmd.wr_shift;
  assign wr_addr = cmd.wr_add ? occ[IW-1:0] : idx[IW-1:0];
  assign rd_addr = cmd.rd_sel_next ? idx_nxt[IW-1:0] : idx[IW-1:0];

  kcal_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  kcal_div #(.W(40)) u_div_range (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (ent.rsum),
    .divisor  (ent.cnt),
    .busy     (busy_r),
    .quotient (q_r)
  );

  kcal_div #(.W(24)) u_div_power (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (ent.psum),
    .divisor  (ent.cnt),
    .busy     (busy_p),
    .quotient (q_p)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= MAX_SAMPLES_RESET;
      occ         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_samples <= cfg_wr_data;
      end
      if (cmd.occ_clr) begin
        occ <= '0;
      end else if (cmd.wr_add) begin
        occ <= occ + 1'b1;
      end else if (cmd.occ_dec) begin
        occ <= occ - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= op;
      addr_q <= anchor_address;
      rs_q   <= range_sample;
      ds_q   <= dbm_sample;
      exp_q  <= expected_anchors;
      st_q   <= ST_OK;
      rep    <= 1'b0;
    end else begin
      if (cmd.st_load) begin
        st_q <= cmd.st_val;
      end
      if (cmd.rep_set) begin
        rep <= 1'b1;
      end
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_nxt[CW-1:0];
    end
    if (cmd.wr_upd) begin
      ent <= upd;
    end else if (cmd.ent_load) begin
      ent <= rd_ent;
    end
    if (cmd.fin_set) begin
      fin <= occ != '0;
    end else if (cmd.fin_and) begin
      fin <= fin & rd_ent.cal;
    end
  end

  assign occ_w16 = {16'b0, occ};
  assign occ_w5  = {5'b0, occ};
  assign exp_ok  = (exp_q == 16'd0) || (occ_w16 == {{CW{1'b0}}, exp_q});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status        <= st_q;
      average_range <= (rep && ent.cnt != 8'd0) ? $signed(q_r[31:0]) : 32'sd0;
      average_dbm   <= (rep && ent.cnt != 8'd0) ? $signed(q_p[15:0]) : 16'sd0;
      sample_count  <= rep ? ent.cnt : 8'd0;
      calibrated    <= rep & ent.cal;
      finished      <= (op_q == OP_FINISH) & fin & exp_ok;
      entry_count   <= occ_w5[4:0];
    end
  end

  assign sts.op         = op_q;
  assign sts.addr_zero  = addr_q == 16'd0;
  assign sts.full       = occ >= CW'(NUM_ENTRIES);
  assign sts.idx_lt_occ = idx < occ;
  assign sts.nxt_lt_occ = idx_nxt < {1'b0, occ};
  assign sts.key_match  = rd_ent.key == addr_q;
  assign sts.rd_cal     = rd_ent.cal;
  assign sts.div_busy   = busy_r | busy_p;
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

// File: hdl/kcal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_ctrl
// Sequencer for table scans, update, delete shifting and division.
// ----------------------------------------------------------------------------
module kcal_ctrl import kcal_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_READ     = 9'b000000100,
    S_CHECK    = 9'b000001000,
    S_DEL_RD   = 9'b000010000,
    S_DEL_WR   = 9'b000100000,
    S_DIV_GO   = 9'b001000000,
    S_DIV_WAIT = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (sts.op)
          OP_ADD: begin
            if (sts.full) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = ST_FULL;
            end else begin
              cmd.wr_add = 1'b1;
            end
          end
          OP_CLEAR: cmd.occ_clr = 1'b1;
          OP_UPDATE, OP_DELETE, OP_QUERY: begin
            if (sts.addr_zero) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = ST_ADDR_ZERO;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = S_READ;
            end
          end
          OP_FINISH: begin
            cmd.fin_set = 1'b1;
            cmd.idx_clr = 1'b1;
            state_next  = S_READ;
          end
          default: ;
        endcase
      end
      S_READ: begin
        if (sts.idx_lt_occ) begin
          cmd.rd_en  = 1'b1;
          state_next = S_CHECK;
        end else begin
          if (sts.op != OP_FINISH) begin
            cmd.st_load = 1'b1;
            cmd.st_val  = ST_NOT_FOUND;
          end
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        if (sts.op == OP_FINISH) begin
          cmd.fin_and = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end else if (sts.key_match) begin
          cmd.ent_load = 1'b1;
          cmd.rep_set  = 1'b1;
          state_next   = S_DIV_GO;
          if (sts.op == OP_UPDATE) begin
            if (sts.rd_cal) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = ST_CALIBRATED;
            end else begin
              cmd.wr_upd = 1'b1;
            end
          end else if (sts.op == OP_DELETE) begin
            state_next = S_DEL_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end
      end
      S_DEL_RD: begin
        if (sts.nxt_lt_occ) begin
          cmd.rd_en       = 1'b1;
          cmd.rd_sel_next = 1'b1;
          state_next      = S_DEL_WR;
        end else begin
          cmd.occ_dec = 1'b1;
          state_next  = S_DIV_GO;
        end
      end
      S_DEL_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_DEL_RD;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/keyed_calibration_averager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_calibration_averager_unit
// Insertion-ordered anchor table with per-entry sample averaging.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with op and its operand fields; a
// transfer happens when in_valid is high and in_stall is low. One item is
// worked on at a time, so in_stall stays high from the cycle after a transfer
// until that item's result is in the output register.
// Output channel: out_valid / out_stall with one result per item, held in an
// output register; the next item may be taken while it waits.
// Sequence: add, clear and undefined ops go from decode straight to the
// output register. Lookups scan the table entry by entry (read port, then
// compare); delete then shifts each later entry down (read, then write).
// Reporting an entry runs the serial dividers (40-bit range sum, one bit a
// cycle). The worst case is a delete with a full table.
// Finished check scans every entry.
// Reset: empties the table (occupancy only; no clearing pass), sets
// max_samples to 10 and drops any pending result.
// A stalled receiver holds the result; the block finishes its current item
// and waits with it until the output register frees.
// ----------------------------------------------------------------------------
module keyed_calibration_averager_unit import kcal_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic [15:0]        anchor_address,
  input  logic signed [31:0] range_sample,
  input  logic signed [15:0] dbm_sample,
  input  logic [15:0]        expected_anchors,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] average_range,
  output logic signed [15:0] average_dbm,
  output logic [7:0]         sample_count,
  output logic               calibrated,
  output logic               finished,
  output logic [4:0]         entry_count
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides each step from datapath flags
  kcal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, accumulation, dividers and result register
  kcal_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (op),
    .anchor_address   (anchor_address),
    .range_sample     (range_sample),
    .dbm_sample       (dbm_sample),
    .expected_anchors (expected_anchors),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .average_range    (average_range),
    .average_dbm      (average_dbm),
    .sample_count     (sample_count),
    .calibrated       (calibrated),
    .finished         (finished),
    .entry_count      (entry_count)
  );

  // an accepted item keeps the input side closed on the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item still in progress");

  // error results never report entry fields
  a_error_no_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_ADDR_ZERO || status == ST_NOT_FOUND ||
                   status == ST_FULL))
    |-> (sample_count == 8'd0 && !calibrated && average_range == 32'sd0 &&
         average_dbm == 16'sd0))
    else $error("entry fields set on an error result");

  // a refused update reports a calibrated entry
  a_refused_is_calibrated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_CALIBRATED) |-> calibrated)
    else $error("already-calibrated status without calibrated mark");

  // finished only comes from the check, which reports no entry
  a_finished_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> (status == ST_OK && sample_count == 8'd0))
    else $error("finished flag on a non-check result");

endmodule
